// ===== design/bounded_double_ended_queue_macros.svh =====
// Assertion helpers used by the queue design file.
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_MACROS_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDEQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BDEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bdeq_pkg.sv =====
`timescale 1ns / 1ps

package bdeq_pkg;

    localparam int BDEQ_DEPTH      = 256;
    localparam int BDEQ_DATA_WIDTH = 32;

    // Command codes carried in the low bits of the request.
    typedef enum logic [2:0] {
        CMD_PEEK       = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_PUSH_BACK  = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_POP_BACK   = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_DONE       = 2'd0,
        STAT_FULL       = 2'd1,
        STAT_EMPTY      = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_FINISH = 1'b1
    } state_t;

endpackage

// ===== design/bounded_double_ended_queue.sv =====
`timescale 1ns / 1ps
// A request accepted at one clock edge has its result loaded into the output
// register at the next edge, provided the output side has taken the previous result.
// The block takes no new request until that result is loaded, since it is ready
// only in its idle state and moves to the finish state on every accepted request.
// Reset clears the control state, head index and count; the element memory is not cleared.

`include "bounded_double_ended_queue_macros.svh"

module bounded_double_ended_queue
    import bdeq_pkg::*;
#(
    parameter int DEPTH      = BDEQ_DEPTH,
    parameter int DATA_WIDTH = BDEQ_DATA_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // Fields from bit 0 up: command[2:0], value[34:3], zero padding to 40 bits.
    input  logic [39:0]          s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // Fields from bit 0 up: status[1:0], front_value[33:2], back_value[65:34],
    // length[65+CW:66], is_empty[66+CW], zero padding to whole bytes.
    output logic [((2 + 32 + 32 + $clog2(DEPTH + 1) + 1 + 7) / 8) * 8 - 1:0] m_tdata
);

    // Widths derived from the capacity. The count needs one more state than an
    // index so that a full queue can be told apart from an empty one.
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SW    = CW + 1;
    localparam int OUT_W = ((2 + 32 + 32 + CW + 1 + 7) / 8) * 8;

    // ------------------------------------------------------------------
    // Control and cached end values.
    // The front and back elements are kept in registers so that a push can
    // report them at once. Only a pop needs the memory, to fetch the element
    // that becomes the new end.
    // ------------------------------------------------------------------
    state_t                  state_reg,    state_next;
    logic [AW-1:0]           head_reg,     head_next;
    logic [CW-1:0]           count_reg,    count_next;
    logic [DATA_WIDTH-1:0]   front_reg,    front_next;
    logic [DATA_WIDTH-1:0]   back_reg,     back_next;
    status_t                 status_reg,   status_next;
    logic                    rd_front_reg, rd_front_next;
    logic                    rd_back_reg,  rd_back_next;

    // Output register, which decouples the result from the next request.
    logic                    out_valid_reg, out_valid_next;
    status_t                 out_status_reg, out_status_next;
    logic [31:0]             out_front_reg,  out_front_next;
    logic [31:0]             out_back_reg,   out_back_next;
    logic [CW-1:0]           out_len_reg,    out_len_next;
    logic                    out_load;

    // Element memory ports.
    logic [DATA_WIDTH-1:0]   mem [DEPTH];
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic [DATA_WIDTH-1:0]   mem_wdata;
    logic                    mem_re;
    logic [AW-1:0]           mem_raddr;
    logic [DATA_WIDTH-1:0]   rd_data_reg;

    // Request decode and ring address arithmetic.
    logic                    req_accept;
    cmd_t                    cmd;
    logic [63:0]             value_ext;
    logic                    is_full;
    logic                    is_zero;
    logic [AW-1:0]           head_dec;
    logic [AW-1:0]           head_inc;
    logic [SW-1:0]           tail_sum;
    logic [AW-1:0]           tail_addr;
    logic [SW-1:0]           last2_sum;
    logic [AW-1:0]           last2_addr;
    logic [63:0]             front_ext;
    logic [63:0]             back_ext;

    assign s_tready   = (state_reg == ST_IDLE);
    assign req_accept = s_tvalid & s_tready;
    assign cmd        = cmd_t'(s_tdata[2:0]);
    assign value_ext  = 64'(s_tdata[34:3]);

    assign is_full  = (count_reg == CW'(DEPTH));
    assign is_zero  = (count_reg == '0);
    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - AW'(1);
    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + AW'(1);

    // Slot after the last element, used by a push to the back. The sum stays
    // below twice the capacity, so one conditional subtract wraps it.
    assign tail_sum  = SW'(head_reg) + SW'(count_reg);
    assign tail_addr = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH))
                                                : AW'(tail_sum);

    // Slot of the element just before the last one, which becomes the back
    // after a pop from the back. Only used when at least two elements exist.
    assign last2_sum  = tail_sum - SW'(2);
    assign last2_addr = (last2_sum >= SW'(DEPTH)) ? AW'(last2_sum - SW'(DEPTH))
                                                  : AW'(last2_sum);

    // ------------------------------------------------------------------
    // Next state. In the idle state a request is taken, the memory write or
    // neighbor read is issued and the index and count are updated. In the
    // finish state the read data is folded into the cached ends and the
    // result is loaded once the output register is free.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        front_next      = front_reg;
        back_next       = back_reg;
        status_next     = status_reg;
        rd_front_next   = rd_front_reg;
        rd_back_next    = rd_back_reg;
        out_valid_next  = out_valid_reg & ~m_tready;
        out_status_next = out_status_reg;
        out_front_next  = out_front_reg;
        out_back_next   = out_back_reg;
        out_len_next    = out_len_reg;
        out_load        = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = head_reg;
        mem_wdata       = value_ext[DATA_WIDTH-1:0];
        mem_re          = 1'b0;
        mem_raddr       = head_inc;
        front_ext       = '0;
        back_ext        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    state_next    = ST_FINISH;
                    status_next   = STAT_DONE;
                    rd_front_next = 1'b0;
                    rd_back_next  = 1'b0;
                    unique case (cmd)
                        CMD_PUSH_FRONT:
                        begin
                            if (is_full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = head_dec;
                                head_next  = head_dec;
                                count_next = count_reg + CW'(1);
                                front_next = value_ext[DATA_WIDTH-1:0];
                                if (is_zero)
                                begin
                                    back_next = value_ext[DATA_WIDTH-1:0];
                                end
                            end
                        end
                        CMD_PUSH_BACK:
                        begin
                            if (is_full)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = tail_addr;
                                count_next = count_reg + CW'(1);
                                back_next  = value_ext[DATA_WIDTH-1:0];
                                if (is_zero)
                                begin
                                    front_next = value_ext[DATA_WIDTH-1:0];
                                end
                            end
                        end
                        CMD_POP_FRONT:
                        begin
                            if (is_zero)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                head_next  = head_inc;
                                count_next = count_reg - CW'(1);
                                // The element behind the front becomes the front.
                                if (count_reg != CW'(1))
                                begin
                                    mem_re        = 1'b1;
                                    mem_raddr     = head_inc;
                                    rd_front_next = 1'b1;
                                end
                            end
                        end
                        CMD_POP_BACK:
                        begin
                            if (is_zero)
                            begin
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                                if (count_reg != CW'(1))
                                begin
                                    mem_re       = 1'b1;
                                    mem_raddr    = last2_addr;
                                    rd_back_next = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            // Peek, and the unused codes, leave the state alone.
                        end
                    endcase
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    if (rd_front_reg)
                    begin
                        front_next = rd_data_reg;
                    end
                    if (rd_back_reg)
                    begin
                        back_next = rd_data_reg;
                    end
                    front_ext       = 64'(front_next);
                    back_ext        = 64'(back_next);
                    out_load        = 1'b1;
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_front_next  = is_zero ? 32'd0 : front_ext[31:0];
                    out_back_next   = is_zero ? 32'd0 : back_ext[31:0];
                    out_len_next    = count_reg;
                    rd_front_next   = 1'b0;
                    rd_back_next    = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            status_reg    <= STAT_DONE;
            rd_front_reg  <= 1'b0;
            rd_back_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            status_reg    <= status_next;
            rd_front_reg  <= rd_front_next;
            rd_back_reg   <= rd_back_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Cached ends and the result payload need no reset: they are only shown
    // when the count says an element exists or when the output is valid.
    always_ff @(posedge clk)
    begin
        front_reg <= front_next;
        back_reg  <= back_next;
        if (out_load)
        begin
            out_status_reg <= out_status_next;
            out_front_reg  <= out_front_next;
            out_back_reg   <= out_back_next;
            out_len_reg    <= out_len_next;
        end
    end

    // Element memory: one write port, one read port with registered data.
    // A pop only reads entries written by earlier requests, so the read and
    // write of one request never meet at the same entry.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    assign m_tvalid = out_valid_reg;
    // The packed fields are zero-extended up to the byte-aligned bus width.
    assign m_tdata  = OUT_W'({(out_len_reg == '0), out_len_reg,
                              out_back_reg, out_front_reg, out_status_reg});

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `BDEQ_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(DEPTH),
        "element count exceeds the capacity")

    `BDEQ_ASSERT_NEXT(a_accept_finish, clk, rst_n, req_accept, state_reg == ST_FINISH,
        "accepted request did not move to the finish state")

    `BDEQ_ASSERT_NEXT(a_finish_result, clk, rst_n,
        (state_reg == ST_FINISH) && (!out_valid_reg || m_tready), out_valid_reg,
        "finished request did not produce a result")

    `BDEQ_ASSERT_NEXT(a_push_count, clk, rst_n,
        req_accept && (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK) && !is_full,
        count_reg == $past(count_reg) + CW'(1),
        "push did not grow the count by one")

    `BDEQ_ASSERT_SAME(a_read_one_end, clk, rst_n, 1'b1, !(rd_front_reg && rd_back_reg),
        "neighbor read marked for both ends")

endmodule

// ===== tb/sv/bdeq_checker.sv =====
`timescale 1ns / 1ps

module bdeq_checker
    import bdeq_pkg::*;
#(
    parameter int REQUEST_W = 40,
    parameter int RESULT_W  = 80
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [REQUEST_W-1:0] s_tdata,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [RESULT_W-1:0]  m_tdata,
    output int                   mismatches,
    output int                   outstanding
);

    localparam int DW    = BDEQ_DATA_WIDTH;
    localparam int LEN_W = $clog2(BDEQ_DEPTH + 1);

    // What the block should report after one request.
    typedef struct {
        int unsigned      tag;
        status_t          status;
        logic [DW-1:0]    front_value;
        logic [DW-1:0]    back_value;
        logic [LEN_W-1:0] length;
        logic             is_empty;
    } deque_view_t;

    // Shadow copy of the ring store, its head and its element count.
    logic [DW-1:0] ring [BDEQ_DEPTH];
    int unsigned   head;
    int unsigned   count;
    int unsigned   requests_seen;
    int unsigned   results_seen;
    deque_view_t   views_due[$];

    // Applies one request to the shadow deque and returns the view it leaves.
    function automatic deque_view_t apply_request(logic [2:0] code, logic [DW-1:0] word);
        deque_view_t v;
        v.tag    = requests_seen;
        v.status = STAT_DONE;
        case (code)
            CMD_PUSH_FRONT:
                if (count == BDEQ_DEPTH) begin
                    v.status = STAT_FULL;
                end
                else begin
                    head       = (head + BDEQ_DEPTH - 1) % BDEQ_DEPTH;
                    ring[head] = word;
                    count++;
                end
            CMD_PUSH_BACK:
                if (count == BDEQ_DEPTH) begin
                    v.status = STAT_FULL;
                end
                else begin
                    ring[(head + count) % BDEQ_DEPTH] = word;
                    count++;
                end
            CMD_POP_FRONT:
                if (count == 0) begin
                    v.status = STAT_EMPTY;
                end
                else begin
                    head = (head + 1) % BDEQ_DEPTH;
                    count--;
                end
            CMD_POP_BACK:
                if (count == 0) begin
                    v.status = STAT_EMPTY;
                end
                else begin
                    count--;
                end
            default: ;  // Peek and the spare codes leave everything as it is.
        endcase
        v.front_value = '0;
        v.back_value  = '0;
        if (count != 0) begin
            v.front_value = ring[head];
            v.back_value  = ring[(head + count - 1) % BDEQ_DEPTH];
        end
        v.length   = LEN_W'(count);
        v.is_empty = (count == 0);
        return v;
    endfunction

    task automatic report_mismatch(string what, int unsigned tag, logic [63:0] want,
                                   logic [63:0] got);
        if (mismatches < 30)
            $display("[%0t] request %0d: %s expected %0h, got %0h", $time, tag, what, want, got);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        deque_view_t want;
        if (!rst_n) begin
            head          = 0;
            count         = 0;
            requests_seen = 0;
            results_seen  = 0;
            mismatches    = 0;
            views_due.delete();
            outstanding   = 0;
        end
        else begin
            // Results first, so a request taken at the same edge queues behind them.
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (views_due.size() == 0) begin
                    report_mismatch("result with nothing pending", results_seen, '0,
                                    m_tdata[63:0]);
                end
                else begin
                    want = views_due.pop_front();
                    if (m_tdata[1:0] !== want.status)
                        report_mismatch("status", want.tag, want.status, m_tdata[1:0]);
                    if (m_tdata[2 +: DW] !== want.front_value)
                        report_mismatch("front_value", want.tag, want.front_value,
                                        m_tdata[2 +: DW]);
                    if (m_tdata[2 + DW +: DW] !== want.back_value)
                        report_mismatch("back_value", want.tag, want.back_value,
                                        m_tdata[2 + DW +: DW]);
                    if (m_tdata[2 + 2 * DW +: LEN_W] !== want.length)
                        report_mismatch("length", want.tag, want.length,
                                        m_tdata[2 + 2 * DW +: LEN_W]);
                    if (m_tdata[2 + 2 * DW + LEN_W] !== want.is_empty)
                        report_mismatch("is_empty", want.tag, want.is_empty,
                                        m_tdata[2 + 2 * DW + LEN_W]);
                end
            end
            if (s_tvalid && s_tready) begin
                requests_seen++;
                views_due.push_back(apply_request(s_tdata[2:0], s_tdata[3 +: DW]));
            end
            outstanding = views_due.size();
        end
    end

endmodule

// ===== tb/sv/tb_bounded_double_ended_queue.sv =====
`timescale 1ns / 1ps

module tb_bounded_double_ended_queue;
    import bdeq_pkg::*;

    localparam int DW        = BDEQ_DATA_WIDTH;
    localparam int LEN_W     = $clog2(BDEQ_DEPTH + 1);
    localparam int REQUEST_W = ((3 + DW + 7) / 8) * 8;
    localparam int RESULT_W  = ((2 + 2 * DW + LEN_W + 1 + 7) / 8) * 8;

    // Longest random gap either side may insert before a transfer.
    localparam int MAX_IDLE     = 17;
    // Length of the deliberate stall on the result side.
    localparam int LONG_HOLD    = 120;
    // Idle stretch after the last result, a little margin before the summary.
    localparam int SETTLE_CYCLES = 8;
    // The slowest legal run stays far below this.
    localparam int CYCLE_LIMIT  = 400000;
    // Requests spent pulling elements back out of the filled queue.
    localparam int DRAIN_REQUESTS = 60;

    // Codes past the last defined command; the block must treat them as a peek.
    localparam logic [2:0] CMD_SPARE_A = 3'd5;
    localparam logic [2:0] CMD_SPARE_B = 3'd6;
    localparam logic [2:0] CMD_SPARE_C = 3'd7;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    // Fields from bit 0 up: command, value, zero padding.
    logic [REQUEST_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    // Fields from bit 0 up: status, front_value, back_value, length, is_empty, padding.
    logic [RESULT_W-1:0]  m_tdata;

    int          mismatches;
    int          outstanding;
    int unsigned cycles;

    // Stimulus bookkeeping: the sender keeps a count of the occupancy so it
    // can steer the random walk toward a full queue and report the peak.
    int unsigned sent;
    int unsigned occupancy;
    int unsigned peak;
    int unsigned full_hits;
    int unsigned empty_hits;
    int unsigned spare_hits;

    // Each side runs in bursts of back-to-back transfers now and then.
    bit send_steady;
    bit take_steady;
    // Set by the stimulus to make the result side stall for a long stretch.
    bit long_hold;

    bounded_double_ended_queue dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    bdeq_checker #(
        .REQUEST_W (REQUEST_W),
        .RESULT_W  (RESULT_W)
    ) deque_monitor (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial cycles = 0;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles with %0d results still due", cycles,
                     outstanding);
            $display("status: fail");
            $finish;
        end
    end

    // Picks a command code. The push and pop shares are in percent; whatever is
    // left goes to any code at all, including peek and the spare codes.
    function automatic logic [2:0] pick_command(int unsigned push_pct, int unsigned pop_pct);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
            return ($urandom_range(0, 1) != 0) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        if (roll < push_pct + pop_pct)
            return ($urandom_range(0, 1) != 0) ? CMD_POP_FRONT : CMD_POP_BACK;
        return 3'($urandom_range(0, 7));
    endfunction

    // Offers one request, waits until the block takes it, and returns at the
    // falling edge right after the transfer. The random gap in front of the
    // request is what spreads idle cycles over every phase of the block's work.
    task automatic send_request(logic [2:0] code, logic [DW-1:0] word);
        int unsigned          gap;
        logic [REQUEST_W-1:0] packed_request;
        if (sent % 30 == 0)
            send_steady = ($urandom_range(0, 3) == 0);
        gap = send_steady ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        packed_request         = '0;
        packed_request[2:0]    = code;
        packed_request[3 +: DW] = word;
        s_tvalid <= 1'b1;
        s_tdata  <= packed_request;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);

        sent++;
        case (code)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
                if (occupancy == BDEQ_DEPTH)
                    full_hits++;
                else
                    occupancy++;
            CMD_POP_FRONT, CMD_POP_BACK:
                if (occupancy == 0)
                    empty_hits++;
                else
                    occupancy--;
            CMD_PEEK: ;
            default:
                spare_hits++;
        endcase
        if (occupancy > peak)
            peak = occupancy;
    endtask

    // Result side. Before each result it draws a random gap with ready low;
    // when asked it holds off for a long stretch so the block backs up and
    // has to stall its request side.
    initial
    begin : result_taker
        int unsigned gap;
        int unsigned taken;
        m_tready    = 1'b0;
        take_steady = 1'b0;
        taken       = 0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (long_hold)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold = 1'b0;
            end
            if (taken % 40 == 0)
                take_steady = ($urandom_range(0, 3) == 0);
            gap = take_steady ? 0 : $urandom_range(0, MAX_IDLE);
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            @(negedge clk);
            taken++;
        end
    end

    initial
    begin : stimulus
        int unsigned goal;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        long_hold   = 1'b0;
        send_steady = 1'b0;
        sent        = 0;
        occupancy   = 0;
        peak        = 0;
        full_hits   = 0;
        empty_hits  = 0;
        spare_hits  = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed opening: pops on an empty queue, peeks and spare codes on
        // empty and non-empty queues, the all-zero and all-one words, both
        // ends of the queue, and a push to the front right after the queue
        // drains so that the head index wraps below zero.
        send_request(CMD_POP_FRONT, $urandom());
        send_request(CMD_POP_BACK, $urandom());
        send_request(CMD_PEEK, $urandom());
        send_request(CMD_SPARE_A, $urandom());
        send_request(CMD_PUSH_BACK, 32'h0000_0000);
        send_request(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
        send_request(CMD_PEEK, $urandom());
        send_request(CMD_PUSH_BACK, 32'h5555_5555);
        send_request(CMD_PUSH_FRONT, 32'hAAAA_AAAA);
        send_request(CMD_SPARE_B, $urandom());
        send_request(CMD_SPARE_C, $urandom());
        send_request(CMD_POP_BACK, $urandom());
        send_request(CMD_POP_FRONT, $urandom());
        send_request(CMD_POP_BACK, $urandom());
        send_request(CMD_POP_FRONT, $urandom());
        send_request(CMD_POP_BACK, $urandom());
        send_request(CMD_PUSH_FRONT, 32'h0000_0001);
        send_request(CMD_PUSH_BACK, 32'h8000_0000);
        send_request(CMD_POP_FRONT, $urandom());
        send_request(CMD_POP_BACK, $urandom());

        // Let the block run completely dry before the random part starts.
        s_tvalid <= 1'b0;
        wait (outstanding == 0);
        @(negedge clk);

        // Balanced random walk, opened by a long stall on the result side
        // while requests keep coming.
        long_hold = 1'b1;
        repeat (30) send_request(pick_command(35, 35), $urandom());

        // Fill the queue past capacity, so pushes are turned away as full and
        // the ring wraps around with content of random origin at both ends.
        goal = full_hits + 8;
        while (full_hits < goal)
            send_request(pick_command(92, 4), $urandom());

        // Pull a good part of it back out, so pops fetch new ends from all
        // over the wrapped ring.
        repeat (DRAIN_REQUESTS) send_request(pick_command(4, 92), $urandom());

        // A last balanced stretch with another long stall.
        long_hold = 1'b1;
        repeat (40) send_request(pick_command(35, 35), $urandom());

        s_tvalid <= 1'b0;
        wait (outstanding == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("covered %0d requests (%0d with spare codes) in %0d cycles, occupancy up to %0d of %0d",
                 sent, spare_hits, cycles, peak, BDEQ_DEPTH);
        $display("%0d pushes met a full queue, %0d pops met an empty one, %0d mismatches",
                 full_hits, empty_hits, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
